// File: sv/swrh_pkg.sv
package swrh_pkg;

    localparam int unsigned US_PER_MS = 1000;
    localparam int unsigned PRE_W     = 10;
    localparam logic [15:0] MIN_RUN_RESET = 16'd500;
    localparam logic [31:0] ELAPSED_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_TOGGLE = 3'd1,
        REQ_ARM    = 3'd2,
        REQ_START  = 3'd3,
        REQ_STOP   = 3'd4,
        REQ_SETPWR = 3'd5,
        REQ_CLEAR  = 3'd6,
        REQ_READ   = 3'd7
    } t_req;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_ARMED   = 4'b0010,
        PH_RUNNING = 4'b0100,
        PH_STOPPED = 4'b1000
    } t_phase;

    localparam logic [1:0] CODE_IDLE    = 2'd0;
    localparam logic [1:0] CODE_ARMED   = 2'd1;
    localparam logic [1:0] CODE_RUNNING = 2'd2;
    localparam logic [1:0] CODE_STOPPED = 2'd3;

    typedef struct packed {
        logic [31:0] ms;
        logic [15:0] sp;
    } t_entry;

    typedef struct packed {
        logic clr;
        logic shift;
    } t_cell_ctl;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        case (ph)
            PH_IDLE:    code = CODE_IDLE;
            PH_ARMED:   code = CODE_ARMED;
            PH_RUNNING: code = CODE_RUNNING;
            PH_STOPPED: code = CODE_STOPPED;
            default:    code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: sv/swrh_cell.sv
module swrh_cell (
    input  logic                i_clk,
    input  swrh_pkg::t_cell_ctl i_ctl,
    input  logic                i_load,
    input  swrh_pkg::t_entry    i_new,
    input  swrh_pkg::t_entry    i_nb,
    output swrh_pkg::t_entry    o_entry
);

    swrh_pkg::t_entry r_entry;
    swrh_pkg::t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.clr) begin
            n_entry = '0;
        end else if (i_ctl.shift) begin
            n_entry = i_nb;
        end else if (i_load) begin
            n_entry = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: sv/stopwatch_with_run_history.sv
// stopwatch with run history
// input channel: i_in_valid / o_in_stall carry one request word (req_type,
// sp_value, entry_index); a word is taken when valid is high and stall low.
// output channel: o_out_valid / i_out_stall carry one result word per request,
// showing the state after the request acted, plus the slot read on a read.
// the result word is registered and appears in the cycle after its request is accepted.
// throughput is one request per cycle; the single output register is the
// only buffer, so a stalled result holds the input off until it is taken.
// saved runs sit in a row of HISTORY_DEPTH cells; a save into a full row
// shifts every cell one step toward slot 0 in the same cycle.
// configuration: i_cfg_valid / o_cfg_ready write min_run_ms; ready is
// always high. write it only while no request is in flight.
// reset (i_rst_n low, synchronous) sets mode off, phase idle, counts to zero,
// min_run_ms to 500 and empties the history; no result word is pending.
module stopwatch_with_run_history #(
    parameter int unsigned HISTORY_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_sp_value,
    input  logic [3:0]  i_entry_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_mode_on,
    output logic [1:0]  o_run_phase,
    output logic [31:0] o_elapsed_ms,
    output logic [4:0]  o_run_total,
    output logic [31:0] o_entry_ms,
    output logic [15:0] o_entry_sp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned RD   = (HISTORY_DEPTH < 16) ? HISTORY_DEPTH : 16;
    localparam int unsigned CMPW = (CW > 4) ? CW : 4;

    logic                          r_mode, n_mode;
    swrh_pkg::t_phase              r_phase, n_phase;
    logic [swrh_pkg::PRE_W-1:0]    r_pre, n_pre;
    logic [swrh_pkg::PRE_W-1:0]    w_pre_inc;
    logic [31:0]                   r_elapsed, n_elapsed;
    logic [15:0]                   r_held, n_held;
    logic [CW-1:0]                 r_count, n_count;
    logic [15:0]                   r_min_run;

    logic        r_out_valid;
    logic        r_out_mode;
    logic [1:0]  r_out_phase;
    logic [31:0] r_out_elapsed;
    logic [4:0]  r_out_total;
    logic [31:0] r_out_ems;
    logic [15:0] r_out_esp;

    logic              w_in_acc;
    logic              w_end_run;
    logic              w_save;
    logic              w_full;
    logic              w_clear;
    swrh_pkg::t_req    w_req;
    swrh_pkg::t_entry  w_new;
    swrh_pkg::t_entry  w_rd;
    swrh_pkg::t_cell_ctl w_ctl;
    swrh_pkg::t_entry  w_cell [HISTORY_DEPTH];

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign w_req      = swrh_pkg::t_req'(i_req_type);
    assign w_full     = (r_count == CW'(HISTORY_DEPTH));
    assign w_pre_inc  = r_pre + 1'b1;
    assign w_new.ms   = r_elapsed;
    assign w_new.sp   = r_held;

    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_pre     = r_pre;
        n_elapsed = r_elapsed;
        n_held    = r_held;
        w_end_run = 1'b0;
        w_clear   = 1'b0;
        case (w_req)
            swrh_pkg::REQ_TICK: begin
                if (r_phase == swrh_pkg::PH_RUNNING) begin
                    n_pre = w_pre_inc;
                    if (w_pre_inc >= swrh_pkg::PRE_W'(swrh_pkg::US_PER_MS)) begin
                        n_pre = '0;
                        if (r_elapsed != swrh_pkg::ELAPSED_MAX) begin
                            n_elapsed = r_elapsed + 32'd1;
                        end
                    end
                end
            end
            swrh_pkg::REQ_TOGGLE: begin
                n_phase = swrh_pkg::PH_IDLE;
                if (r_mode) begin
                    w_end_run = (r_phase == swrh_pkg::PH_RUNNING);
                    n_mode    = 1'b0;
                end else begin
                    n_mode    = 1'b1;
                    n_elapsed = '0;
                    n_held    = '0;
                end
            end
            swrh_pkg::REQ_ARM: begin
                if (r_mode) begin
                    w_end_run = (r_phase == swrh_pkg::PH_RUNNING);
                    n_elapsed = '0;
                    n_held    = '0;
                    n_phase   = swrh_pkg::PH_ARMED;
                end
            end
            swrh_pkg::REQ_START: begin
                if (r_mode && r_phase == swrh_pkg::PH_ARMED) begin
                    n_pre     = '0;
                    n_elapsed = '0;
                    n_phase   = swrh_pkg::PH_RUNNING;
                end
            end
            swrh_pkg::REQ_STOP: begin
                if (r_phase == swrh_pkg::PH_RUNNING) begin
                    w_end_run = 1'b1;
                    n_phase   = swrh_pkg::PH_STOPPED;
                end
            end
            swrh_pkg::REQ_SETPWR: begin
                n_held = i_sp_value;
            end
            swrh_pkg::REQ_CLEAR: begin
                w_clear = 1'b1;
                n_held  = '0;
                if (r_phase != swrh_pkg::PH_RUNNING) begin
                    n_elapsed = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_save = w_end_run && (r_elapsed >= {16'd0, r_min_run});

    always_comb begin
        n_count = r_count;
        if (w_clear) begin
            n_count = '0;
        end else if (w_save && !w_full) begin
            n_count = r_count + 1'b1;
        end
    end

    assign w_ctl.clr   = w_in_acc && w_clear;
    assign w_ctl.shift = w_in_acc && w_save && w_full;

    // history row, slot 0 oldest; each cell takes its upper neighbor on shift
    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        swrh_pkg::t_entry w_nb;
        if (k == HISTORY_DEPTH - 1) begin : g_last
            assign w_nb = w_new;
        end else begin : g_mid
            assign w_nb = w_cell[k+1];
        end
        swrh_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_load  (w_in_acc && w_save && !w_full && (r_count == CW'(k))),
            .i_new   (w_new),
            .i_nb    (w_nb),
            .o_entry (w_cell[k])
        );
    end

    always_comb begin
        w_rd = '0;
        if (w_req == swrh_pkg::REQ_READ &&
            CMPW'(i_entry_index) < CMPW'(r_count)) begin
            for (int j = 0; j < RD; j++) begin
                if (i_entry_index == 4'(j)) begin
                    w_rd = w_cell[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_phase   <= swrh_pkg::PH_IDLE;
            r_pre     <= '0;
            r_elapsed <= '0;
            r_held    <= '0;
            r_count   <= '0;
            r_min_run <= swrh_pkg::MIN_RUN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_min_run <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_mode    <= n_mode;
                r_phase   <= n_phase;
                r_pre     <= n_pre;
                r_elapsed <= n_elapsed;
                r_held    <= n_held;
                r_count   <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_mode    <= n_mode;
            r_out_phase   <= swrh_pkg::phase_code(n_phase);
            r_out_elapsed <= n_elapsed;
            r_out_total   <= 5'(n_count);
            r_out_ems     <= w_rd.ms;
            r_out_esp     <= w_rd.sp;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mode_on    = r_out_mode;
    assign o_run_phase  = r_out_phase;
    assign o_elapsed_ms = r_out_elapsed;
    assign o_run_total  = r_out_total;
    assign o_entry_ms   = r_out_ems;
    assign o_entry_sp   = r_out_esp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HISTORY_DEPTH))
        else $error("saved run count beyond history depth");

    a_phase_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != swrh_pkg::PH_IDLE) |-> r_mode)
        else $error("active phase with mode off");

    a_pre_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pre < swrh_pkg::PRE_W'(swrh_pkg::US_PER_MS))
        else $error("prescaler out of range");

    a_clear_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_req == swrh_pkg::REQ_CLEAR) |=> (o_run_total == 5'd0))
        else $error("history not empty after clear");

endmodule
